// ===== rtl/b64enc_pkg.sv =====
// shared types, constants and the base64 alphabet for the stream encoder
package b64enc_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CHAR_W     = 7;
   localparam int unsigned GROUP_W    = 24;
   localparam int unsigned SEXTET_W   = 6;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CHAR_PAD   = 7'd61;  // '='
   localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'd65;  // 'A'
   localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'd97;  // 'a'
   localparam logic [CHAR_W-1:0] CHAR_DIGIT = 7'd48;  // '0'
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'd43;  // '+'
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'd47;  // '/'

   // number of trailing pad characters in a group
   typedef enum logic [1:0] {
      PAD_NONE = 2'd0,
      PAD_ONE  = 2'd1,
      PAD_TWO  = 2'd2
   } pad_type;

   // one classified group, handed from the front to the back
   typedef struct packed {
      logic [GROUP_W-1:0] group;
      pad_type            pad;
      logic               eom;
   } grp_type;

   // queue head as seen by the back
   typedef struct packed {
      logic    valid;
      grp_type entry;
   } qhead_type;

   // back status for checks at the top level
   typedef struct packed {
      logic [1:0] idx;
      logic       pop;
   } back_stat_type;

   function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
      logic [CHAR_W-1:0] v7;
      v7 = {1'b0, v};
      if (v < 6'd26) begin
         sextet_char = CHAR_UPPER + v7;
      end else if (v < 6'd52) begin
         sextet_char = CHAR_LOWER + v7 - 7'd26;
      end else if (v < 6'd62) begin
         sextet_char = CHAR_DIGIT + v7 - 7'd52;
      end else if (v == 6'd62) begin
         sextet_char = CHAR_PLUS;
      end else begin
         sextet_char = CHAR_SLASH;
      end
   endfunction

endpackage

// ===== rtl/b64enc_ifs.sv =====
// valid/ready channel interfaces for the byte input and the character output
interface b64enc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64enc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       last_char;

   modport source (output valid, output out_char, output last_char, input ready);
   modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ===== rtl/b64enc_front.sv =====
// front: collects bytes into groups of three and classifies closed groups
module b64enc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [b64enc_pkg::BYTE_W-1:0]   in_byte,
   input  logic                            in_eom,
   input  logic                            push_ready,
   output logic                            in_ready,
   output logic                            push_valid,
   output b64enc_pkg::grp_type             push_entry
);
   import b64enc_pkg::*;

   logic [2*BYTE_W-1:0] pend_ff, pend_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic [1:0]          held;
   logic                accept;

   assign in_ready = push_ready;
   assign accept   = in_valid && push_ready;
   // held count of three cannot occur; treated as two
   assign held     = (cnt_ff == 2'd3) ? 2'd2 : cnt_ff;

   always_comb begin
      pend_in          = pend_ff;
      cnt_in           = cnt_ff;
      push_valid       = 1'b0;
      push_entry.group = {pend_ff, in_byte};
      push_entry.pad   = PAD_NONE;
      push_entry.eom   = in_eom;
      unique case (held)
         2'd2: begin
            push_valid = in_valid;
            if (accept) begin
               pend_in = '0;
               cnt_in  = 2'd0;
            end
         end
         2'd1: begin
            push_entry.group = {pend_ff[BYTE_W-1:0], in_byte, {BYTE_W{1'b0}}};
            push_entry.pad   = PAD_ONE;
            push_valid       = in_valid && in_eom;
            if (accept) begin
               pend_in = in_eom ? '0 : {pend_ff[BYTE_W-1:0], in_byte};
               cnt_in  = in_eom ? 2'd0 : 2'd2;
            end
         end
         default: begin
            push_entry.group = {in_byte, {2*BYTE_W{1'b0}}};
            push_entry.pad   = PAD_TWO;
            push_valid       = in_valid && in_eom;
            if (accept) begin
               pend_in = in_eom ? '0 : {pend_ff[BYTE_W-1:0], in_byte};
               cnt_in  = in_eom ? 2'd0 : 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         cnt_ff  <= 2'd0;
      end else begin
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// ===== rtl/b64enc_queue.sv =====
// short group queue between front and back
module b64enc_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  b64enc_pkg::grp_type          push_entry,
   output logic                         push_ready,
   input  logic                         pop,
   output b64enc_pkg::qhead_type        head,
   output logic [b64enc_pkg::QCNT_W-1:0] count
);
   import b64enc_pkg::*;

   grp_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign push_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && (cnt_ff != '0);
   assign head.valid = (cnt_ff != '0);
   assign head.entry = mem_ff[rd_ff];
   assign count      = cnt_ff;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      priority case (1'b1)
         do_push && !do_pop: cnt_in = cnt_ff + 1'b1;
         do_pop && !do_push: cnt_in = cnt_ff - 1'b1;
         default:            cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/b64enc_back.sv =====
// back: turns each queued group into four characters, one per cycle while out_ready allows
module b64enc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  b64enc_pkg::qhead_type         head,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [b64enc_pkg::CHAR_W-1:0] out_char,
   output logic                          out_last,
   output b64enc_pkg::back_stat_type     stat
);
   import b64enc_pkg::*;

   logic [1:0]          idx_ff, idx_in;
   logic                vld_ff, vld_in;
   logic [CHAR_W-1:0]   chr_ff, chr_in;
   logic                last_ff, last_in;
   logic                load;
   logic [SEXTET_W-1:0] sx;
   logic                is_pad;

   assign load = !vld_ff || out_ready;

   always_comb begin
      unique case (idx_ff)
         2'd0: sx = head.entry.group[23:18];
         2'd1: sx = head.entry.group[17:12];
         2'd2: sx = head.entry.group[11:6];
         default: sx = head.entry.group[5:0];
      endcase
      is_pad = ((idx_ff == 2'd3) && (head.entry.pad != PAD_NONE)) ||
               ((idx_ff == 2'd2) && (head.entry.pad == PAD_TWO));
   end

   always_comb begin
      idx_in  = idx_ff;
      vld_in  = vld_ff;
      chr_in  = chr_ff;
      last_in = last_ff;
      pop     = 1'b0;
      if (load) begin
         vld_in = head.valid;
         if (head.valid) begin
            chr_in  = is_pad ? CHAR_PAD : sextet_char(sx);
            last_in = head.entry.eom && (idx_ff == 2'd3);
            idx_in  = idx_ff + 2'd1;
            pop     = (idx_ff == 2'd3);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      chr_ff  <= chr_in;
      last_ff <= last_in;
   end

   assign out_valid = vld_ff;
   assign out_char  = chr_ff;
   assign out_last  = last_ff;
   assign stat.idx  = idx_ff;
   assign stat.pop  = pop;

endmodule

// ===== rtl/base64_stream_encoder.sv =====
// path: an accepted closing byte's group is written into the group queue, then its first character
//   is loaded into the back's output register; four characters per group leave at one per cycle
//   from that register while out_ready allows and a group is queued
// the two-entry group queue lets the front keep taking bytes while the back drains
// reset: synchronous, active high; clears held bytes, byte count, queue pointers and
//   output valid; character payload registers are not reset
module base64_stream_encoder (
   input  logic          clock,
   input  logic          reset,
   b64enc_req_if.sink    req,
   b64enc_rsp_if.source  rsp
);
   import b64enc_pkg::*;

   // front to queue
   logic          push_valid;
   logic          push_ready;
   grp_type       push_entry;

   // queue to back
   qhead_type     head;
   logic          pop;
   logic [QCNT_W-1:0] q_count;

   back_stat_type back_stat;

   // front: holds up to two pending bytes and closes groups on the third
   // byte or on end of message, tagging the pad count
   b64enc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req.valid),
      .in_byte    (req.data_byte),
      .in_eom     (req.end_of_message),
      .push_ready (push_ready),
      .in_ready   (req.ready),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // group queue decouples byte intake from character output
   b64enc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .head       (head),
      .count      (q_count)
   );

   // back: serializes a group into four characters with padding
   b64enc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_char  (rsp.out_char),
      .out_last  (rsp.last_char),
      .stat      (back_stat)
   );

   // a group enters the queue only with an accepted item
   a_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_ready) |-> (req.valid && req.ready))
      else $error("group pushed without an accepted item");

   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= QCNT_W'(QUEUE_DEPTH))
      else $error("group queue over depth");

   // a last character is always the fourth of its group
   a_last_is_fourth: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.last_char) |-> (back_stat.idx == 2'd0 || $past(back_stat.pop)))
      else $error("last character not at end of group");

   // popping a group needs a queued group
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      back_stat.pop |-> (head.valid && back_stat.idx == 2'd3))
      else $error("pop from empty queue or mid-group");

endmodule
